[rtl/tmf_pkg.sv]
// Shared types and constants for the multichannel trimmed-mean ADC filter.
// No dependencies; used by the channel interfaces and the top-level filter module.
package tmf_pkg;

    // Field widths fixed by the item format
    localparam int CH_FIELD_W = 2;
    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 6;
    localparam int SUM_W      = 18;
    localparam int LEVEL_W    = 16;

    // Saturation point of the joined sample
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

    // Q0.16 of a 12-bit value over 4096 is a left shift by four
    localparam int Q16_SHIFT = LEVEL_W - SAMPLE_W;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [BYTE_W-1:0]     sample_high;
        logic [BYTE_W-1:0]     sample_low;
    } t_in_item;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] result_channel;
        logic [SAMPLE_W-1:0]   trimmed_mean;
        logic [LEVEL_W-1:0]    normalized_level;
    } t_out_item;

endpackage

[rtl/tmf_in_if.sv]
// Sample channel: valid/ready handshake carrying one ADC byte pair per item.
// Depends on tmf_pkg for the item type.
interface tmf_in_if import tmf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tmf_out_if.sv]
// Result channel: valid/ready handshake carrying one window result per item.
// Depends on tmf_pkg for the item type.
interface tmf_out_if import tmf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tmf_recip_div.sv]
// Division of an unsigned value by a constant via reciprocal multiplication.
// Exact floor quotient for every NUM_W-bit numerator. Does not import tmf_pkg.
module tmf_recip_div #(
    parameter int NUM_W   = 18,
    parameter int DIVISOR = 6
) (
    input  logic [NUM_W-1:0] i_num,
    output logic [NUM_W-1:0] o_quo
);
    // m = ceil(2^(N+l) / d) with l = ceil(log2 d) is exact for all x < 2^N
    localparam int              LOG_D    = $clog2(DIVISOR);
    localparam int              SH       = NUM_W + LOG_D;
    localparam int              PROD_W   = SH + NUM_W;
    localparam longint unsigned RECIP_L  =
        ((64'd1 << SH) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
    localparam logic [NUM_W:0]  RECIP    = (NUM_W+1)'(RECIP_L);

    // Wide enough that the quotient slice above the shift stays in range
    logic [PROD_W-1:0] product;

    assign product = PROD_W'(i_num) * PROD_W'(RECIP);
    assign o_quo   = product[SH +: NUM_W];
endmodule

[rtl/multichannel_trimmed_mean_adc_filter.sv]
// Multichannel trimmed-mean ADC filter. One item per clock is accepted without pause on
// any mix of channels while the output is not stalled; a closing sample passes through the
// input register, the per-channel state update with trimmed-sum register and the
// constant-divider multiply into the output register; backpressure stalls the whole pipe.
// Per channel the count, sum, minimum and maximum live in flip-flops, so samples for the
// same channel may follow each other directly. Every WINDOW samples a channel emits
// (sum - min - max) / (WINDOW - 2) and the same value as a Q0.16 fraction of 4096.
// Items for a channel at or above CHANNELS are dropped. Depends on tmf_pkg, tmf_in_if,
// tmf_out_if and tmf_recip_div.
module multichannel_trimmed_mean_adc_filter import tmf_pkg::*; #(
    parameter int CHANNELS = 4,
    parameter int WINDOW   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmf_in_if.sink    i_in,
    tmf_out_if.source o_out
);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = 5;

    // Pipeline valids and payload registers
    logic                  r_v0, r_v1, r_v2;
    t_in_item              r_in;
    logic [CH_FIELD_W-1:0] r_ch1;
    logic [SUM_W-1:0]      r_num;
    t_out_item             r_out;

    // Per-channel window state
    logic [COUNT_W-1:0]  r_cnt [CHANNELS];
    logic [SUM_W-1:0]    r_sum [CHANNELS];
    logic [SAMPLE_W-1:0] r_min [CHANNELS];
    logic [SAMPLE_W-1:0] r_max [CHANNELS];

    logic en0, en1, en2;
    logic [CH_W-1:0]     idx;
    logic                ch_ok;
    logic [2*BYTE_W-1:0] raw;
    logic [SAMPLE_W-1:0] smp;
    logic                first;
    logic [COUNT_W-1:0]  n_cnt;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] n_min, n_max;
    logic                full;
    logic [SUM_W-1:0]    quo;
    logic [SAMPLE_W-1:0] mean;

    // Stall chain: a stage loads when it is empty or its contents move on
    assign en2        = !r_v2 || o_out.ready;
    assign en1        = !r_v1 || en2;
    assign en0        = !r_v0 || en1;
    assign i_in.ready = en0;

    // Join the bytes and saturate to 12 bits
    assign raw = {r_in.sample_high, r_in.sample_low};
    assign smp = (raw > {{(2*BYTE_W-SAMPLE_W){1'b0}}, SAMPLE_MAX}) ? SAMPLE_MAX
                                                                   : raw[SAMPLE_W-1:0];

    // Channel lookup
    assign idx   = CH_W'(r_in.channel);
    assign ch_ok = {{(CMP_W-CH_FIELD_W){1'b0}}, r_in.channel} < CMP_W'(CHANNELS);

    // Window update for the sample in the input register
    always_comb begin
        first = (r_cnt[idx] == '0);
        n_cnt = r_cnt[idx] + COUNT_W'(1);
        n_sum = (first ? '0 : r_sum[idx]) + {{(SUM_W-SAMPLE_W){1'b0}}, smp};
        n_min = (first || smp < r_min[idx]) ? smp : r_min[idx];
        n_max = (first || smp > r_max[idx]) ? smp : r_max[idx];
        full  = {1'b0, n_cnt} == (COUNT_W+1)'(WINDOW);
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en0) begin
            r_v0 <= i_in.valid;
        end
        if (en0 && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // Channel state and trimmed-sum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c] <= '0;
                r_sum[c] <= '0;
            end
        end else if (en1) begin
            r_v1 <= r_v0 && ch_ok && full;
            if (r_v0 && ch_ok) begin
                r_cnt[idx] <= full ? '0 : n_cnt;
                r_sum[idx] <= full ? '0 : n_sum;
            end
        end
        if (en1 && r_v0 && ch_ok) begin
            r_min[idx] <= n_min;
            r_max[idx] <= n_max;
            r_ch1      <= r_in.channel;
            r_num      <= n_sum - {{(SUM_W-SAMPLE_W){1'b0}}, n_min}
                                - {{(SUM_W-SAMPLE_W){1'b0}}, n_max};
        end
    end

    // Divide by WINDOW - 2
    tmf_recip_div #(
        .NUM_W   (SUM_W),
        .DIVISOR (WINDOW - 2)
    ) u_div (
        .i_num (r_num),
        .o_quo (quo)
    );

    assign mean = (quo > {{(SUM_W-SAMPLE_W){1'b0}}, SAMPLE_MAX}) ? SAMPLE_MAX
                                                                 : quo[SAMPLE_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2 && r_v1) begin
            r_out.result_channel   <= r_ch1;
            r_out.trimmed_mean     <= mean;
            r_out.normalized_level <= {mean, {Q16_SHIFT{1'b0}}};
        end
    end

    assign o_out.valid = r_v2;
    assign o_out.data  = r_out;

    // Checks
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v0)
        else $error("accepted item not captured in input register");

    a_level_matches_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.normalized_level
                         == {o_out.data.trimmed_mean, {Q16_SHIFT{1'b0}}}))
        else $error("normalized level disagrees with trimmed mean");

    a_result_channel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({{(CMP_W-CH_FIELD_W){1'b0}}, o_out.data.result_channel}
                         < CMP_W'(CHANNELS)))
        else $error("result for a channel outside the configured range");

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && ch_ok) |-> ({1'b0, r_cnt[idx]} < (COUNT_W+1)'(WINDOW)))
        else $error("window count reached or passed the window size");

endmodule
